@@ src/itoa_pkg.sv @@
// Shared types, constants and helpers for the integer-to-ASCII converter.
`default_nettype none
package itoa_pkg;

	// Default sizing
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 10;

	// One digit is one BCD or hex nibble
	localparam int DIGIT_W = 4;

	// Radix select codes
	localparam logic RADIX_DEC = 1'b0;
	localparam logic RADIX_HEX = 1'b1;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// Double-dabble adjust: a digit of five or more gets three added before the shift
	localparam logic [DIGIT_W-1:0] DEC_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DEC_ADJ_ADD = 4'd3;
	localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_EMIT
	} itoa_state_t;

	// Digit value to lower-case ASCII
	function automatic logic [7:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [7:0] d8;
		d8 = {4'd0, d};
		if (d < DEC_BASE) begin
			return CHAR_ZERO + d8;
		end else begin
			return CHAR_A + d8 - {4'd0, DEC_BASE};
		end
	endfunction

endpackage
`default_nettype wire

@@ src/itoa_shift_unit.sv @@
// Shared shift-and-adjust step: one value bit into the digit register per use.
`default_nettype none
module itoa_shift_unit import itoa_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic [MAX_DIGITS*DIGIT_W-1:0] digits,
	input  wire logic                          bit_in,
	input  wire logic                          dec_mode,
	output logic      [MAX_DIGITS*DIGIT_W-1:0] digits_next,
	output logic                               carry_out
);

	logic [MAX_DIGITS*DIGIT_W-1:0] adj;

	// Per-digit add-3 correction in decimal mode; plain nibble shift in hex
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_adj
		assign adj[i*DIGIT_W +: DIGIT_W] =
			(dec_mode && (digits[i*DIGIT_W +: DIGIT_W] >= DEC_ADJ_MIN)) ?
			digits[i*DIGIT_W +: DIGIT_W] + DEC_ADJ_ADD :
			digits[i*DIGIT_W +: DIGIT_W];
	end

	// Shift left by one, new bit at the bottom, top bit falls out
	assign digits_next = {adj[MAX_DIGITS*DIGIT_W-2:0], bit_in};
	assign carry_out   = adj[MAX_DIGITS*DIGIT_W-1];

endmodule
`default_nettype wire

@@ src/integer_to_ascii_digits.sv @@
// Integer to ASCII converter top level: sequencer, digit register and output register.
//
// Usage:
//   Input channel (in_valid / in_stall): one word carries value and radix_sel.
//   radix_sel = 0 prints value as signed decimal, 1 as unsigned lower-case hex.
//   Output channel (out_valid / out_stall): one ASCII character per word,
//   most significant first, a leading '-' for negative decimal values, and
//   last set on the final character. Zero prints as a single '0'.
// Timing:
//   After a word is accepted the shared shift-and-adjust unit runs once per
//   value bit, then the find state locates the leading digit, then one
//   character leaves per cycle while the output is not stalled (sign plus
//   digits). in_stall stays high from acceptance until the last character
//   has been loaded into the output register, so a new word can be taken
//   while that character waits.
// Reset:
//   arst_n clears the sequencer and the output valid; no clearing pass.
// Stall:
//   A stalled output word holds; the sequencer waits with it before emitting the next character.
`default_nettype none
module integer_to_ascii_digits import itoa_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic                          radix_sel,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic             [7:0]             out_char,
	output logic                               last
);

	localparam int BCW  = $clog2(VALUE_WIDTH);
	localparam int IDXW = $clog2(MAX_DIGITS);
	localparam int DW   = MAX_DIGITS * DIGIT_W;

	itoa_state_t state_q, state_nxt;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [DW-1:0]          digits_q;
	logic [BCW-1:0]         bit_cnt_q;
	logic [IDXW-1:0]        idx_q;
	logic                   ovf_q;
	logic                   dec_q;
	logic                   neg_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;

	logic [VALUE_WIDTH-1:0] value_u;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [DW-1:0]          digits_next;
	logic                   carry_out;
	logic [IDXW-1:0]        top_idx;

	logic accept;
	logic out_free;
	logic emit_sign;
	logic emit_digit;

	// Magnitude of the incoming word; wraps for the most negative value
	assign value_u = value;
	assign neg_in  = (radix_sel == RADIX_DEC) && value_u[VALUE_WIDTH-1];
	assign mag_in  = neg_in ? (VALUE_WIDTH'(0) - value_u) : value_u;

	// Shared shift unit
	itoa_shift_unit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_shift (
		.digits      (digits_q),
		.bit_in      (mag_q[VALUE_WIDTH-1]),
		.dec_mode    (dec_q),
		.digits_next (digits_next),
		.carry_out   (carry_out)
	);

	// Leading digit position; full width once digits were dropped off the top
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (digits_q[i*DIGIT_W +: DIGIT_W] != '0) top_idx = IDXW'(i);
		end
		if (ovf_q) top_idx = IDXW'(MAX_DIGITS - 1);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_CONV;
			ST_CONV: if (bit_cnt_q == '0) state_nxt = ST_FIND;
			ST_FIND: state_nxt = neg_q ? ST_SIGN : ST_EMIT;
			ST_SIGN: if (out_free) state_nxt = ST_EMIT;
			ST_EMIT: if (out_free && (idx_q == '0)) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		in_stall   = 1'b1;
		accept     = 1'b0;
		emit_sign  = 1'b0;
		emit_digit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			ST_SIGN: emit_sign  = out_free;
			ST_EMIT: emit_digit = out_free;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath: load, shift per bit, pick leading digit, count down on emit
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= mag_in;
			digits_q  <= '0;
			ovf_q     <= 1'b0;
			dec_q     <= (radix_sel == RADIX_DEC);
			neg_q     <= neg_in;
			bit_cnt_q <= BCW'(VALUE_WIDTH - 1);
		end else if (state_q == ST_CONV) begin
			mag_q     <= mag_q << 1;
			digits_q  <= digits_next;
			ovf_q     <= ovf_q | carry_out;
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end
		if (state_q == ST_FIND) begin
			idx_q <= top_idx;
		end else if (emit_digit && (idx_q != '0)) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_sign || emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit_sign) begin
			out_char_q <= CHAR_MINUS;
			last_q     <= 1'b0;
		end else if (emit_digit) begin
			out_char_q <= digit_ascii(digits_q[idx_q*DIGIT_W +: DIGIT_W]);
			last_q     <= (idx_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	// Checks
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_CONV)
		else $error("accepted word did not start conversion");

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV && bit_cnt_q == '0 |=> state_q == ST_FIND)
		else $error("conversion did not end after the last bit");

	a_final_digit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_digit && idx_q == '0 |=> state_q == ST_IDLE && out_valid && last)
		else $error("final digit not marked last");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CHAR_MINUS |-> !last)
		else $error("sign character marked last");

endmodule
`default_nettype wire
